### rtl/qdc_pkg.sv
package qdc_pkg;

   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOCKOUT_US = 2'd2;

   localparam logic CMD_PIN_SAMPLE = 1'b0;
   localparam logic CMD_BUTTON     = 1'b1;

   typedef logic [1:0] phase_type;

   localparam phase_type PHASE_00 = 2'b00;
   localparam phase_type PHASE_01 = 2'b01;
   localparam phase_type PHASE_10 = 2'b10;
   localparam phase_type PHASE_11 = 2'b11;

   localparam longint MAX_COUNT_RESET  = 10000000;
   localparam longint MIN_COUNT_RESET  = 1;
   localparam longint LOCKOUT_RESET    = 100000;
   localparam longint COUNT_RESET      = 1;
   localparam phase_type PHASE_RESET   = PHASE_11;

   // encoder sample fields held in the input register
   typedef struct packed {
      logic      autoset;
      phase_type phase;
   } pin_sample_type;

endpackage

### rtl/qdc_decoder.sv
module qdc_decoder #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  qdc_pkg::phase_type     phase,
   input  logic [COUNT_WIDTH-1:0] max_count,
   input  logic [COUNT_WIDTH-1:0] min_count,
   output logic [COUNT_WIDTH-1:0] count_next,
   output logic                   stepped
);
   import qdc_pkg::*;

   phase_type              phase_ff, phase_in;
   logic                   armed_ff, armed_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH:0]   up_sum;
   logic [COUNT_WIDTH:0]   down_floor;

   assign up_sum     = {1'b0, count_ff} + (COUNT_WIDTH+1)'(1);
   assign down_floor = {1'b0, min_count} + (COUNT_WIDTH+1)'(1);

   always_comb begin
      phase_in = phase_ff;
      armed_in = armed_ff;
      count_in = count_ff;
      stepped  = 1'b0;
      if (step_en && (phase != phase_ff)) begin
         phase_in = phase;
         armed_in = 1'b0;
         if ((phase == PHASE_11) && (phase_ff == PHASE_10) && armed_ff) begin
            stepped = 1'b1;
            if (up_sum >= {1'b0, max_count}) begin
               count_in = max_count;
            end else begin
               count_in = up_sum[COUNT_WIDTH-1:0];
            end
         end else if ((phase == PHASE_11) && (phase_ff == PHASE_01) && armed_ff) begin
            stepped = 1'b1;
            if ({1'b0, count_ff} <= down_floor) begin
               count_in = min_count;
            end else begin
               count_in = count_ff - COUNT_WIDTH'(1);
            end
         end else if (((phase == PHASE_10) || (phase == PHASE_01)) &&
                      (phase_ff == PHASE_00) && !armed_ff) begin
            armed_in = 1'b1;
         end
      end
   end

   assign count_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_RESET;
         armed_ff <= 1'b0;
         count_ff <= COUNT_WIDTH'(COUNT_RESET);
      end else begin
         phase_ff <= phase_in;
         armed_ff <= armed_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/qdc_lockout.sv
module qdc_lockout #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  event_en,
   input  logic [TIME_WIDTH-1:0] now_us,
   input  logic [TIME_WIDTH-1:0] lockout_us,
   output logic                  confirm
);
   import qdc_pkg::*;

   logic [TIME_WIDTH-1:0] last_ff, last_in;
   logic [TIME_WIDTH-1:0] gap;

   // gap only meaningful when now_us is past the last confirmation
   assign gap     = now_us - last_ff;
   assign confirm = event_en && (now_us > last_ff) && (gap > lockout_us);
   assign last_in = confirm ? now_us : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

endmodule

### rtl/quadrature_detent_counter.sv
// Rotary encoder detent counter. Send encoder pin samples (req_tuser = 0) and
// button events (req_tuser = 1) as req beats; every beat gives exactly one rsp
// beat with the count after that item and the set strobe. One beat is taken per
// clock while no stalled result blocks it: the beat is held in an input
// register, then the decoder and the lockout compare run in one pass into the
// result register, and a stalled result holds the input side only once the
// input register is also full. csr_index 0 writes max_count, 1 min_count,
// 2 lockout_us; write only while no beat is in flight.
module quadrature_detent_counter #(
   parameter int COUNT_WIDTH = 24,
   parameter int TIME_WIDTH  = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // enc_a, enc_b, autoset, now_us
   input  logic [((TIME_WIDTH+3+7)/8)*8-1:0] req_tdata,
   // cmd
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // count
   output logic [((COUNT_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // set_strobe
   output logic rsp_tuser,
   input  logic csr_we,
   input  logic [qdc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [((COUNT_WIDTH > TIME_WIDTH) ? COUNT_WIDTH : TIME_WIDTH)-1:0] csr_wdata
);
   import qdc_pkg::*;

   localparam int RSP_DATA_WIDTH = ((COUNT_WIDTH+7)/8)*8;

   logic [COUNT_WIDTH-1:0] max_count_ff;
   logic [COUNT_WIDTH-1:0] min_count_ff;
   logic [TIME_WIDTH-1:0]  lockout_ff;

   logic                   in_valid_ff;
   logic                   in_cmd_ff;
   pin_sample_type         in_pins_ff;
   logic [TIME_WIDTH-1:0]  in_now_ff;

   logic                   rsp_valid_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;

   logic                   advance;
   logic                   stepped;
   logic                   confirm;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff <= COUNT_WIDTH'(MAX_COUNT_RESET);
         min_count_ff <= COUNT_WIDTH'(MIN_COUNT_RESET);
         lockout_ff   <= TIME_WIDTH'(LOCKOUT_RESET);
      end else if (csr_we) begin
         case (csr_index)
            REG_MAX_COUNT:  max_count_ff <= csr_wdata[COUNT_WIDTH-1:0];
            REG_MIN_COUNT:  min_count_ff <= csr_wdata[COUNT_WIDTH-1:0];
            REG_LOCKOUT_US: lockout_ff   <= csr_wdata[TIME_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff          <= req_tuser;
         in_pins_ff.phase   <= {req_tdata[0], req_tdata[1]};
         in_pins_ff.autoset <= req_tdata[2];
         in_now_ff          <= req_tdata[TIME_WIDTH+2:3];
      end
   end

   qdc_decoder #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_decoder (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance && (in_cmd_ff == CMD_PIN_SAMPLE)),
      .phase      (in_pins_ff.phase),
      .max_count  (max_count_ff),
      .min_count  (min_count_ff),
      .count_next (rsp_count_in),
      .stepped    (stepped)
   );

   qdc_lockout #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_lockout (
      .clock      (clock),
      .reset      (reset),
      .event_en   (advance && (in_cmd_ff == CMD_BUTTON)),
      .now_us     (in_now_ff),
      .lockout_us (lockout_ff),
      .confirm    (confirm)
   );

   assign rsp_strobe_in = (in_cmd_ff == CMD_BUTTON) ? confirm
                                                    : (stepped && in_pins_ff.autoset);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_count_ff  <= rsp_count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'(rsp_count_ff);
   assign rsp_tuser  = rsp_strobe_ff;

endmodule

### rtl/qdc_checker.sv
module qdc_checker #(
   parameter int COUNT_WIDTH = 24
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((COUNT_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input logic rsp_tuser
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid straight after reset");

   // a new result only follows an accepted req beat, through the input register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("rsp beat without matching req beat");

   // input side only stalls behind a stalled result
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req stalled without rsp stall");

endmodule

bind quadrature_detent_counter qdc_checker #(
   .COUNT_WIDTH (COUNT_WIDTH)
) u_qdc_checker (.*);

### test/tb.sv
`timescale 1ns / 100ps

module tb;
   import qdc_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   typedef struct {
      logic        cmd;
      logic        enc_a;
      logic        enc_b;
      logic        autoset;
      logic [31:0] now_us;
   } detent_beat_type;

   typedef struct {
      logic [23:0] count;
      logic        strobe;
   } readout_type;

   typedef enum {ROW_PIN, ROW_BUTTON, ROW_CSR} row_kind_type;

   // sel is the pin phase for beats, the register index for ROW_CSR
   typedef struct {
      row_kind_type kind;
      logic [1:0]   sel;
      logic         autoset;
      logic [31:0]  value;
      bit           typed;
      logic [23:0]  count;
      logic         strobe;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = CMD_PIN_SAMPLE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_MAX_COUNT;
   logic [31:0] csr_wdata = '0;

   // predictor state and register copies
   logic [23:0] max_cnt, min_cnt, cnt;
   logic [31:0] lockout, last_press, press_clock;
   phase_type   last_phase;
   logic        detent_armed;

   readout_type expected_readouts[$];
   int mismatches = 0;
   int quiet_cycles = 0;
   int beats_sent = 0;
   int rsp_hold = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   script_row_type script [32] = '{
      '{ROW_PIN,    PHASE_00, 1'b0, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_01, 1'b0, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_11, 1'b1, 32'd0,          1'b1, 24'd1, 1'b1},
      '{ROW_PIN,    PHASE_00, 1'b0, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_10, 1'b0, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_11, 1'b1, 32'd0,          1'b1, 24'd2, 1'b1},
      '{ROW_PIN,    PHASE_00, 1'b1, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_10, 1'b1, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_01, 1'b1, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_11, 1'b1, 32'd0,          1'b1, 24'd2, 1'b0},
      '{ROW_BUTTON, PHASE_11, 1'b1, 32'd0,          1'b1, 24'd2, 1'b0},
      '{ROW_BUTTON, PHASE_11, 1'b1, 32'd100001,     1'b1, 24'd2, 1'b1},
      '{ROW_BUTTON, PHASE_00, 1'b0, 32'hFFFF_FFFF,  1'b1, 24'd2, 1'b1},
      '{ROW_BUTTON, PHASE_11, 1'b1, 32'hFFFF_FFFF,  1'b1, 24'd2, 1'b0},
      '{ROW_CSR,    REG_MAX_COUNT,  1'b0, 32'd1,         1'b0, 24'd0, 1'b0},
      '{ROW_CSR,    REG_MIN_COUNT,  1'b0, 32'd0,         1'b0, 24'd0, 1'b0},
      '{ROW_CSR,    REG_LOCKOUT_US, 1'b0, 32'hFFFF_FFFF, 1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_00, 1'b0, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_10, 1'b0, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_11, 1'b1, 32'd0,          1'b1, 24'd1, 1'b1},
      '{ROW_PIN,    PHASE_00, 1'b0, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_01, 1'b0, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_11, 1'b0, 32'd0,          1'b1, 24'd0, 1'b0},
      '{ROW_CSR,    REG_MAX_COUNT,  1'b0, 32'd3,         1'b0, 24'd0, 1'b0},
      '{ROW_CSR,    REG_MIN_COUNT,  1'b0, 32'd5,         1'b0, 24'd0, 1'b0},
      '{ROW_CSR,    REG_LOCKOUT_US, 1'b0, 32'd0,         1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_00, 1'b0, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_01, 1'b0, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_11, 1'b1, 32'd0,          1'b1, 24'd5, 1'b1},
      '{ROW_PIN,    PHASE_00, 1'b0, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_10, 1'b0, 32'd0,          1'b0, 24'd0, 1'b0},
      '{ROW_PIN,    PHASE_11, 1'b1, 32'd0,          1'b1, 24'd3, 1'b1}
   };

   always #5 clock = ~clock;

   quadrature_detent_counter #(
      .COUNT_WIDTH(24),
      .TIME_WIDTH(32)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   function automatic readout_type step_counter(detent_beat_type b);
      readout_type r;
      phase_type   ph;
      r.strobe = 1'b0;
      if (b.cmd == CMD_PIN_SAMPLE) begin
         ph = {b.enc_a, b.enc_b};
         if (ph != last_phase) begin
            if (ph == PHASE_11 && last_phase == PHASE_10 && detent_armed) begin
               if ({1'b0, cnt} + 25'd1 >= {1'b0, max_cnt}) cnt = max_cnt;
               else cnt = cnt + 24'd1;
               r.strobe = b.autoset;
               detent_armed = 1'b0;
            end else if (ph == PHASE_11 && last_phase == PHASE_01 && detent_armed) begin
               if ({1'b0, cnt} <= {1'b0, min_cnt} + 25'd1) cnt = min_cnt;
               else cnt = cnt - 24'd1;
               r.strobe = b.autoset;
               detent_armed = 1'b0;
            end else if ((ph == PHASE_10 || ph == PHASE_01) && last_phase == PHASE_00
                         && !detent_armed) begin
               detent_armed = 1'b1;
            end else begin
               detent_armed = 1'b0;
            end
            last_phase = ph;
         end
      end else if (b.now_us > last_press && b.now_us - last_press > lockout) begin
         last_press = b.now_us;
         r.strobe = 1'b1;
      end
      r.count = cnt;
      return r;
   endfunction

   function automatic int pick_gap(bit calm);
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_beat(detent_beat_type b, bit typed, readout_type want);
      int          gap;
      readout_type r;
      if ($urandom_range(0, 47) == 0) req_calm = !req_calm;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= b.cmd;
      req_tdata <= {5'b0, b.now_us, b.autoset, b.enc_b, b.enc_a};
      do @(posedge clock); while (!req_tready);
      r = step_counter(b);
      expected_readouts.push_back(typed ? want : r);
      beats_sent++;
   endtask

   task automatic send_pin(phase_type ph);
      detent_beat_type b;
      readout_type     none;
      b.cmd = CMD_PIN_SAMPLE;
      {b.enc_a, b.enc_b} = ph;
      b.autoset = $urandom_range(0, 1);
      b.now_us = $urandom;
      none = '{24'd0, 1'b0};
      send_beat(b, 1'b0, none);
   endtask

   task automatic send_press();
      detent_beat_type b;
      readout_type     none;
      b.cmd = CMD_BUTTON;
      {b.enc_a, b.enc_b, b.autoset} = 3'($urandom);
      case ($urandom_range(0, 9))
         0: b.now_us = $urandom;
         1: b.now_us = last_press + lockout;
         2: b.now_us = last_press + lockout + 32'd1;
         3: b.now_us = 32'hFFFF_FFFF;
         4: b.now_us = 32'd0;
         5: b.now_us = last_press + 32'($urandom_range(0, 100));
         default: begin
            press_clock = press_clock + 32'($urandom_range(0, 200000));
            b.now_us = press_clock;
         end
      endcase
      none = '{24'd0, 1'b0};
      send_beat(b, 1'b0, none);
   endtask

   // only once every beat has come back
   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      req_tvalid <= 1'b0;
      while (expected_readouts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_MAX_COUNT:  max_cnt = val[23:0];
         REG_MIN_COUNT:  min_cnt = val[23:0];
         REG_LOCKOUT_US: lockout = val;
         default: ;
      endcase
   endtask

   task automatic configure(logic [23:0] mx, logic [23:0] mn, logic [31:0] lk);
      write_reg(REG_MAX_COUNT, {8'b0, mx});
      write_reg(REG_MIN_COUNT, {8'b0, mn});
      write_reg(REG_LOCKOUT_US, lk);
   endtask

   // mostly clean detents with random repeats, some presses, some pin noise
   task automatic run_random(int n);
      int        target;
      int        roll;
      phase_type mid;
      target = beats_sent + n;
      while (beats_sent < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            mid = (roll < 35) ? PHASE_10 : PHASE_01;
            send_pin(PHASE_00);
            if ($urandom_range(0, 3) == 0) send_pin(PHASE_00);
            send_pin(mid);
            if ($urandom_range(0, 3) == 0) send_pin(mid);
            send_pin(PHASE_11);
            if ($urandom_range(0, 5) == 0) send_pin(PHASE_11);
         end else if (roll < 85) begin
            send_press();
         end else begin
            send_pin(phase_type'($urandom_range(0, 3)));
         end
      end
   endtask

   always @(posedge clock) begin : rsp_side
      readout_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readouts.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual count %0d strobe %0b",
                     $time, rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = expected_readouts.pop_front();
            if (rsp_tdata !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count, rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser !== want.strobe) begin
               $display("%0t: set strobe expected %0b actual %0b", $time, want.strobe,
                        rsp_tuser);
               mismatches++;
            end
         end
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
         rsp_hold = $urandom_range(0, 1) ? 0 : pick_gap(rsp_calm);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      detent_beat_type b;
      readout_type     want;
      max_cnt = 24'(MAX_COUNT_RESET);
      min_cnt = 24'(MIN_COUNT_RESET);
      lockout = 32'(LOCKOUT_RESET);
      cnt = 24'(COUNT_RESET);
      last_phase = PHASE_RESET;
      detent_armed = 1'b0;
      last_press = 32'd0;
      press_clock = 32'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            write_reg(script[i].sel, script[i].value);
         end else begin
            b.cmd = (script[i].kind == ROW_BUTTON) ? CMD_BUTTON : CMD_PIN_SAMPLE;
            {b.enc_a, b.enc_b} = script[i].sel;
            b.autoset = script[i].autoset;
            b.now_us = (script[i].kind == ROW_BUTTON) ? script[i].value : $urandom;
            want = '{script[i].count, script[i].strobe};
            send_beat(b, script[i].typed, want);
         end
      end

      configure(24'd10000000, 24'd1, 32'd100000);
      run_random(120);
      configure(24'hFF_FFFF, 24'hFF_FFFE, 32'd0);
      run_random(120);
      configure(24'd8, 24'd2, 32'd50);
      run_random(120);
      configure(24'($urandom_range(1, 24'hFF_FFFF)), 24'($urandom_range(0, 24'hFF_FFFF)),
                $urandom);
      run_random(120);
      configure(24'd1, 24'd0, 32'd0);
      run_random(120);
      configure(24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
      run_random(120);
      configure(24'($urandom_range(1, 40)), 24'($urandom_range(0, 40)),
                32'($urandom_range(0, 300000)));
      run_random(120);

      req_tvalid <= 1'b0;
      while (expected_readouts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
